// File: design/fps_pkg.sv
// Shared constants, types and controller/datapath command and status for the funnel path smoother.
`timescale 1ns / 1ps
package fps_pkg;

	localparam int MAX_PORTALS = 32;
	localparam int COORD_BITS  = 16;
	localparam int IDX_W       = $clog2(MAX_PORTALS);
	localparam int CNT_W       = $clog2(MAX_PORTALS + 1);
	localparam int PORTAL_W    = 6 * COORD_BITS;
	localparam int DIFF_W      = COORD_BITS + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int AREA_W      = PROD_W + 1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef struct packed {
		point_t l;
		point_t r;
	} portal_t;

	// Operands of one signed-area test: funnel side against new portal side
	typedef enum logic [1:0] {
		AREA_FR_R = 2'd0,
		AREA_FL_R = 2'd1,
		AREA_FL_L = 2'd2,
		AREA_FR_L = 2'd3
	} area_sel_t;

	typedef enum logic [1:0] {
		RD_FIRST = 2'd0,
		RD_SCAN  = 2'd1,
		RD_TAIL  = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		EMIT_HEAD = 2'd0,
		EMIT_FL   = 2'd1,
		EMIT_FR   = 2'd2,
		EMIT_TAIL = 2'd3
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      rd_en;
		rd_sel_t   rd_sel;
		logic      mul_en;
		area_sel_t area_sel;
		logic      init;
		logic      take_r;
		logic      take_l;
		logic      restart_l;
		logic      restart_r;
		logic      scan_inc;
		logic      emit;
		emit_sel_t emit_sel;
		logic      flush;
		logic      clear;
	} dp_cmd_t;

	typedef struct packed {
		logic area_neg;
		logic area_zero;
		logic apex_is_fl;
		logic apex_is_fr;
		logic tail_repeat;
		logic scan_done;
		logic out_free;
	} dp_stat_t;

endpackage

// File: design/fps_if.sv
// Request channel interfaces: portal input and path point output.
`timescale 1ns / 1ps
interface fps_portal_if;
	logic                  valid;
	logic                  ready;
	fps_pkg::coord_t       left_x;
	fps_pkg::coord_t       left_y;
	fps_pkg::coord_t       left_z;
	fps_pkg::coord_t       right_x;
	fps_pkg::coord_t       right_y;
	fps_pkg::coord_t       right_z;
	logic                  last_portal;

	modport source (output valid, left_x, left_y, left_z, right_x, right_y, right_z,
		last_portal, input ready);
	modport sink (input valid, left_x, left_y, left_z, right_x, right_y, right_z,
		last_portal, output ready);
endinterface

interface fps_point_if;
	logic            valid;
	logic            ready;
	fps_pkg::coord_t point_x;
	fps_pkg::coord_t point_y;
	fps_pkg::coord_t point_z;
	logic            last_point;
	logic            overflow;

	modport source (output valid, point_x, point_y, point_z, last_point, overflow,
		input ready);
	modport sink (input valid, point_x, point_y, point_z, last_point, overflow,
		output ready);
endinterface

// File: design/fps_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module fps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/fps_datapath.sv
// Datapath: portal store, funnel registers, signed-area unit and output register.
`timescale 1ns / 1ps
module fps_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  fps_pkg::portal_t   in_portal,
	input  fps_pkg::dp_cmd_t   cmd,
	output fps_pkg::dp_stat_t  stat,
	fps_point_if.source        path
);

	logic [fps_pkg::CNT_W-1:0] count_q;
	logic [fps_pkg::CNT_W-1:0] scan_q;
	logic [fps_pkg::CNT_W-1:0] tail_cnt;
	logic [fps_pkg::IDX_W-1:0] left_idx_q;
	logic [fps_pkg::IDX_W-1:0] right_idx_q;
	logic [fps_pkg::IDX_W-1:0] raddr;
	logic                      dropped_q;
	logic                      we;
	logic [fps_pkg::PORTAL_W-1:0] rdata;
	fps_pkg::portal_t          rd;
	fps_pkg::point_t           apex_q;
	fps_pkg::point_t           fl_q;
	fps_pkg::point_t           fr_q;
	fps_pkg::point_t           pend_q;
	logic                      pend_vld_q;
	fps_pkg::point_t           out_pt_q;
	logic                      out_vld_q;
	logic                      out_last_q;
	logic                      out_ovf_q;
	fps_pkg::point_t           opb;
	fps_pkg::point_t           opc;
	fps_pkg::point_t           emit_pt;
	logic signed [fps_pkg::DIFF_W-1:0] ax;
	logic signed [fps_pkg::DIFF_W-1:0] az;
	logic signed [fps_pkg::DIFF_W-1:0] bx;
	logic signed [fps_pkg::DIFF_W-1:0] bz;
	logic signed [fps_pkg::PROD_W-1:0] prod_a_q;
	logic signed [fps_pkg::PROD_W-1:0] prod_b_q;
	logic signed [fps_pkg::AREA_W-1:0] area;
	logic                      out_free;

	// Store write while not full
	assign we = cmd.load && (count_q < fps_pkg::CNT_W'(fps_pkg::MAX_PORTALS));
	assign tail_cnt = count_q - fps_pkg::CNT_W'(1);

	// Select the read address
	always_comb begin
		unique case (cmd.rd_sel)
			fps_pkg::RD_FIRST: raddr = '0;
			fps_pkg::RD_SCAN:  raddr = scan_q[fps_pkg::IDX_W-1:0];
			fps_pkg::RD_TAIL:  raddr = tail_cnt[fps_pkg::IDX_W-1:0];
			default:           raddr = '0;
		endcase
	end

	fps_ram #(
		.WIDTH (fps_pkg::PORTAL_W),
		.DEPTH (fps_pkg::MAX_PORTALS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[fps_pkg::IDX_W-1:0]),
		.wdata (in_portal),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd = rdata;

	// Pick the area operands
	always_comb begin
		unique case (cmd.area_sel)
			fps_pkg::AREA_FR_R: begin opb = fr_q; opc = rd.r; end
			fps_pkg::AREA_FL_R: begin opb = fl_q; opc = rd.r; end
			fps_pkg::AREA_FL_L: begin opb = fl_q; opc = rd.l; end
			fps_pkg::AREA_FR_L: begin opb = fr_q; opc = rd.l; end
			default:            begin opb = fr_q; opc = rd.r; end
		endcase
	end

	assign ax = fps_pkg::DIFF_W'($signed(opb.x)) - fps_pkg::DIFF_W'($signed(apex_q.x));
	assign az = fps_pkg::DIFF_W'($signed(opb.z)) - fps_pkg::DIFF_W'($signed(apex_q.z));
	assign bx = fps_pkg::DIFF_W'($signed(opc.x)) - fps_pkg::DIFF_W'($signed(apex_q.x));
	assign bz = fps_pkg::DIFF_W'($signed(opc.z)) - fps_pkg::DIFF_W'($signed(apex_q.z));

	// Register the two cross products
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_a_q <= fps_pkg::PROD_W'(bx * az);
			prod_b_q <= fps_pkg::PROD_W'(ax * bz);
		end
	end

	assign area = fps_pkg::AREA_W'(prod_a_q) - fps_pkg::AREA_W'(prod_b_q);

	// Choose the point to emit
	always_comb begin
		unique case (cmd.emit_sel)
			fps_pkg::EMIT_HEAD: emit_pt = rd.l;
			fps_pkg::EMIT_FL:   emit_pt = fl_q;
			fps_pkg::EMIT_FR:   emit_pt = fr_q;
			fps_pkg::EMIT_TAIL: emit_pt = rd.l;
			default:            emit_pt = rd.l;
		endcase
	end

	assign out_free = !out_vld_q || path.ready;

	assign stat.area_neg    = area[fps_pkg::AREA_W-1];
	assign stat.area_zero   = (area == '0);
	assign stat.apex_is_fl  = (apex_q == fl_q);
	assign stat.apex_is_fr  = (apex_q == fr_q);
	assign stat.tail_repeat = (pend_q == rd.l);
	assign stat.scan_done   = (scan_q >= count_q);
	assign stat.out_free    = out_free;

	// Portal count, drop flag and funnel indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			scan_q      <= '0;
			left_idx_q  <= '0;
			right_idx_q <= '0;
		end else begin
			if (cmd.load) begin
				if (we) begin
					count_q <= count_q + fps_pkg::CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.init) begin
				left_idx_q  <= '0;
				right_idx_q <= '0;
				scan_q      <= fps_pkg::CNT_W'(1);
			end
			if (cmd.take_r) begin
				right_idx_q <= scan_q[fps_pkg::IDX_W-1:0];
			end
			if (cmd.take_l) begin
				left_idx_q <= scan_q[fps_pkg::IDX_W-1:0];
			end
			if (cmd.scan_inc) begin
				scan_q <= scan_q + fps_pkg::CNT_W'(1);
			end
			if (cmd.restart_l) begin
				right_idx_q <= left_idx_q;
				scan_q      <= fps_pkg::CNT_W'(left_idx_q) + fps_pkg::CNT_W'(1);
			end
			if (cmd.restart_r) begin
				left_idx_q <= right_idx_q;
				scan_q     <= fps_pkg::CNT_W'(right_idx_q) + fps_pkg::CNT_W'(1);
			end
			if (cmd.clear) begin
				count_q     <= '0;
				dropped_q   <= 1'b0;
				scan_q      <= '0;
				left_idx_q  <= '0;
				right_idx_q <= '0;
			end
		end
	end

	// Funnel points: apex, left and right
	always_ff @(posedge clk) begin
		if (cmd.init) begin
			apex_q <= rd.l;
			fl_q   <= rd.l;
			fr_q   <= rd.r;
		end
		if (cmd.take_r) begin
			fr_q <= rd.r;
		end
		if (cmd.take_l) begin
			fl_q <= rd.l;
		end
		if (cmd.restart_l) begin
			apex_q <= fl_q;
			fr_q   <= fl_q;
		end
		if (cmd.restart_r) begin
			apex_q <= fr_q;
			fl_q   <= fr_q;
		end
	end

	// Pending point and output register: hold the newest point until its successor shows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_vld_q && path.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cmd.emit) begin
				pend_vld_q <= 1'b1;
				if (pend_vld_q) begin
					out_vld_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				pend_vld_q <= 1'b0;
				out_vld_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_q <= emit_pt;
			if (pend_vld_q) begin
				out_pt_q   <= pend_q;
				out_last_q <= 1'b0;
				out_ovf_q  <= dropped_q;
			end
		end
		if (cmd.flush) begin
			out_pt_q   <= pend_q;
			out_last_q <= 1'b1;
			out_ovf_q  <= dropped_q;
		end
	end

	assign path.valid      = out_vld_q;
	assign path.point_x    = out_pt_q.x;
	assign path.point_y    = out_pt_q.y;
	assign path.point_z    = out_pt_q.z;
	assign path.last_point = out_last_q;
	assign path.overflow   = out_ovf_q;

endmodule

// File: design/fps_ctrl.sv
// Controller: sequences loading, the funnel scan and path emission.
`timescale 1ns / 1ps
module fps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  fps_pkg::dp_stat_t stat,
	output fps_pkg::dp_cmd_t  cmd
);

	typedef enum logic [14:0] {
		S_LOAD    = 15'b000000000000001,
		S_HEAD_RD = 15'b000000000000010,
		S_HEAD    = 15'b000000000000100,
		S_CHECK   = 15'b000000000001000,
		S_MUL_R   = 15'b000000000010000,
		S_EVAL_R  = 15'b000000000100000,
		S_MUL_R2  = 15'b000000001000000,
		S_EVAL_R2 = 15'b000000010000000,
		S_MUL_L   = 15'b000000100000000,
		S_EVAL_L  = 15'b000001000000000,
		S_MUL_L2  = 15'b000010000000000,
		S_EVAL_L2 = 15'b000100000000000,
		S_TAIL_RD = 15'b001000000000000,
		S_TAIL    = 15'b010000000000000,
		S_FINAL   = 15'b100000000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_LOAD);

	// Next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.rd_sel   = fps_pkg::RD_SCAN;
		cmd.area_sel = fps_pkg::AREA_FR_R;
		cmd.emit_sel = fps_pkg::EMIT_HEAD;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						state_d = S_HEAD_RD;
					end
				end
			end
			S_HEAD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = fps_pkg::RD_FIRST;
				state_d    = S_HEAD;
			end
			S_HEAD: begin
				if (stat.out_free) begin
					cmd.init     = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_sel = fps_pkg::EMIT_HEAD;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.scan_done) begin
					state_d = S_TAIL_RD;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_MUL_R;
				end
			end
			S_MUL_R: begin
				cmd.mul_en   = 1'b1;
				cmd.area_sel = fps_pkg::AREA_FR_R;
				state_d      = S_EVAL_R;
			end
			// Right side: area(apex, right, new right) >= 0
			S_EVAL_R: begin
				if (stat.area_neg) begin
					state_d = S_MUL_L;
				end else if (stat.apex_is_fr) begin
					cmd.take_r = 1'b1;
					state_d    = S_MUL_L;
				end else begin
					state_d = S_MUL_R2;
				end
			end
			S_MUL_R2: begin
				cmd.mul_en   = 1'b1;
				cmd.area_sel = fps_pkg::AREA_FL_R;
				state_d      = S_EVAL_R2;
			end
			// Tighten right, or left crossed: left becomes apex
			S_EVAL_R2: begin
				if (stat.area_neg) begin
					cmd.take_r = 1'b1;
					state_d    = S_MUL_L;
				end else if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = fps_pkg::EMIT_FL;
					cmd.restart_l = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_MUL_L: begin
				cmd.mul_en   = 1'b1;
				cmd.area_sel = fps_pkg::AREA_FL_L;
				state_d      = S_EVAL_L;
			end
			// Left side: area(apex, left, new left) <= 0
			S_EVAL_L: begin
				if (!stat.area_neg && !stat.area_zero) begin
					cmd.scan_inc = 1'b1;
					state_d      = S_CHECK;
				end else if (stat.apex_is_fl) begin
					cmd.take_l   = 1'b1;
					cmd.scan_inc = 1'b1;
					state_d      = S_CHECK;
				end else begin
					state_d = S_MUL_L2;
				end
			end
			S_MUL_L2: begin
				cmd.mul_en   = 1'b1;
				cmd.area_sel = fps_pkg::AREA_FR_L;
				state_d      = S_EVAL_L2;
			end
			// Tighten left, or right crossed: right becomes apex
			S_EVAL_L2: begin
				if (!stat.area_neg && !stat.area_zero) begin
					cmd.take_l   = 1'b1;
					cmd.scan_inc = 1'b1;
					state_d      = S_CHECK;
				end else if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = fps_pkg::EMIT_FR;
					cmd.restart_r = 1'b1;
					state_d       = S_CHECK;
				end
			end
			S_TAIL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = fps_pkg::RD_TAIL;
				state_d    = S_TAIL;
			end
			// Append the end point unless it repeats the last one
			S_TAIL: begin
				if (stat.out_free) begin
					if (stat.tail_repeat) begin
						cmd.flush = 1'b1;
						cmd.clear = 1'b1;
						state_d   = S_LOAD;
					end else begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = fps_pkg::EMIT_TAIL;
						state_d      = S_FINAL;
					end
				end
			end
			S_FINAL: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					cmd.clear = 1'b1;
					state_d   = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/funnel_path_smoother.sv
// Top level of the funnel path smoother: portal channel in, path point channel out.
`timescale 1ns / 1ps
// Portals are taken one per cycle and stored (up to 32; later ones are dropped and the
// corridor's points carry overflow). The portal marked last starts the funnel scan,
// during which no portal is taken. The scan reads one stored portal per visit and runs
// two to four signed-area tests on a single registered multiplier pair, each test a
// multiply state that registers the products and an evaluate state; each apex restart
// revisits portals from the new apex. Points leave through an output register, one held
// back so the final one can be marked; the scan stalls only when that register is still
// full. Portals of the next corridor are taken again once the last point is registered.
module funnel_path_smoother (
	input  logic        clk,
	input  logic        arst_n,
	fps_portal_if.sink  portal,
	fps_point_if.source path
);

	fps_pkg::dp_cmd_t  cmd;
	fps_pkg::dp_stat_t stat;
	fps_pkg::portal_t  in_portal;

	// Pack the request payload
	assign in_portal.l.x = portal.left_x;
	assign in_portal.l.y = portal.left_y;
	assign in_portal.l.z = portal.left_z;
	assign in_portal.r.x = portal.right_x;
	assign in_portal.r.y = portal.right_y;
	assign in_portal.r.z = portal.right_z;

	fps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (portal.valid),
		.in_last  (portal.last_portal),
		.in_ready (portal.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fps_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_portal (in_portal),
		.cmd       (cmd),
		.stat      (stat),
		.path      (path)
	);

endmodule

// File: verif/fps_tb_if.sv
// Note: the channel interfaces are defined with the design; this file holds none of its own.
`timescale 1ns / 1ps
package fps_tb_types;
	import fps_pkg::*;

	// One portal request as the driver offers it
	typedef struct packed {
		point_t l;
		point_t r;
		logic   last_portal;
	} portal_req_t;

	// One path point as the monitor expects it
	typedef struct packed {
		point_t p;
		logic   last_point;
		logic   overflow;
	} path_point_t;
endpackage

// File: verif/funnel_path_smoother_tb.sv
// Testbench for the funnel path smoother: directed and random corridors checked against a funnel predictor.
`timescale 1ns / 1ps
module funnel_path_smoother_tb;
	import fps_pkg::*;
	import fps_tb_types::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fps_portal_if portal ();
	fps_point_if  path ();

	funnel_path_smoother u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.portal (portal.sink),
		.path   (path.source)
	);

	always #4 clk = ~clk;

	portal_req_t pending_portals[$];
	path_point_t expected_points[$];
	int          failures = 0;
	int          send_idle_pct = 20;
	int          recv_idle_pct = 58;
	int          hold_off = 0;
	logic        stim_done = 1'b0;
	logic        in_fire = 1'b0;

	// Predictor state
	portal_t store_q[$];
	logic    drop_seen = 1'b0;
	point_t  last_out = '0;

	function automatic longint signed area_of(point_t a, point_t b, point_t c);
		longint signed ax, az, bx, bz;
		ax = longint'(b.x) - longint'(a.x);
		az = longint'(b.z) - longint'(a.z);
		bx = longint'(c.x) - longint'(a.x);
		bz = longint'(c.z) - longint'(a.z);
		return bx * az - ax * bz;
	endfunction

	function automatic void push_point(point_t p);
		path_point_t e;
		e.p = p;
		e.last_point = 1'b0;
		e.overflow = drop_seen;
		expected_points.push_back(e);
		last_out = p;
	endfunction

	// Store a portal and, on the last one, string-pull the corridor
	function automatic void predict_corridor(portal_req_t req);
		point_t apex, fl, fr, l, r;
		int apex_i, left_i, right_i, k;
		path_point_t e;
		portal_t pt;
		pt.l = req.l;
		pt.r = req.r;
		if (store_q.size() < MAX_PORTALS) store_q.push_back(pt);
		else drop_seen = 1'b1;
		if (!req.last_portal) return;
		apex = store_q[0].l;
		fl = store_q[0].l;
		fr = store_q[0].r;
		apex_i = 0;
		left_i = 0;
		right_i = 0;
		push_point(apex);
		k = 1;
		while (k < store_q.size()) begin
			l = store_q[k].l;
			r = store_q[k].r;
			if (area_of(apex, fr, r) >= 0) begin
				if (apex == fr || area_of(apex, fl, r) < 0) begin
					fr = r;
					right_i = k;
				end else begin
					push_point(fl);
					apex = fl;
					apex_i = left_i;
					fr = apex;
					right_i = apex_i;
					k = apex_i + 1;
					continue;
				end
			end
			if (area_of(apex, fl, l) <= 0) begin
				if (apex == fl || area_of(apex, fr, l) > 0) begin
					fl = l;
					left_i = k;
				end else begin
					push_point(fr);
					apex = fr;
					apex_i = right_i;
					fl = apex;
					left_i = apex_i;
					k = apex_i + 1;
					continue;
				end
			end
			k++;
		end
		if (last_out != store_q[store_q.size()-1].l) push_point(store_q[store_q.size()-1].l);
		e = expected_points.pop_back();
		e.last_point = 1'b1;
		expected_points.push_back(e);
		store_q.delete();
		drop_seen = 1'b0;
	endfunction

	function automatic coord_t rand_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 2047)) - 16'sd1024;
			2: return 16'sh7fff;
			default: return 16'sh8000;
		endcase
	endfunction

	function automatic point_t rand_point(int mode);
		point_t p;
		p.x = rand_coord(mode);
		p.y = rand_coord(mode);
		p.z = rand_coord(mode);
		return p;
	endfunction

	// Queue one corridor; a walking corridor mostly, with wild or degenerate portals mixed in
	task automatic queue_corridor(int n);
		portal_req_t req;
		int cx, cz, mode;
		cx = $urandom_range(0, 4000) - 2000;
		cz = $urandom_range(0, 4000) - 2000;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(0, 9);
			cx += $urandom_range(0, 200) - 60;
			cz += $urandom_range(0, 200) - 100;
			if (mode < 7) begin
				req.l.x = coord_t'(cx - $urandom_range(0, 300));
				req.l.z = coord_t'(cz + $urandom_range(0, 300));
				req.r.x = coord_t'(cx + $urandom_range(0, 300));
				req.r.z = coord_t'(cz - $urandom_range(0, 300));
				req.l.y = coord_t'($urandom);
				req.r.y = coord_t'($urandom);
			end else if (mode == 7) begin
				req.l = rand_point(1);
				req.r = req.l;
			end else begin
				req.l = rand_point(0);
				req.r = rand_point(0);
			end
			req.last_portal = (i == n - 1);
			pending_portals.push_back(req);
		end
	endtask

	task automatic queue_fixed(point_t l, point_t r, logic last);
		portal_req_t req;
		req.l = l;
		req.r = r;
		req.last_portal = last;
		pending_portals.push_back(req);
	endtask

	// Drive requests at the falling edge; a new request only once the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!portal.valid || in_fire) begin
				if (pending_portals.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					{portal.left_x, portal.left_y, portal.left_z} <= pending_portals[0].l;
					{portal.right_x, portal.right_y, portal.right_z} <= pending_portals[0].r;
					portal.last_portal <= pending_portals[0].last_portal;
					portal.valid <= 1'b1;
				end else begin
					portal.valid <= 1'b0;
				end
			end
			if (hold_off > 0) path.ready <= 1'b0;
			else path.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Count down a long receive stall
	always @(negedge clk) begin
		if (hold_off > 0) hold_off <= hold_off - 1;
	end

	// Accept requests and check points at the rising edge
	always @(posedge clk) begin
		path_point_t got, want;
		in_fire = arst_n && portal.valid && portal.ready;
		if (arst_n) begin
			if (in_fire) begin
				predict_corridor(pending_portals.pop_front());
			end
			if (path.valid && path.ready) begin
				got.p = {path.point_x, path.point_y, path.point_z};
				got.last_point = path.last_point;
				got.overflow = path.overflow;
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected point got %h", $time, got);
					failures++;
				end else begin
					want = expected_points.pop_front();
					if (got !== want) begin
						$display("%0t: point mismatch expected %h actual %h", $time, want, got);
						failures++;
					end
				end
			end
		end
	end

	initial begin
		point_t hi, lo, z0;
		hi = {16'sh7fff, 16'sh7fff, 16'sh7fff};
		lo = {16'sh8000, 16'sh8000, 16'sh8000};
		z0 = '0;
		portal.valid = 1'b0;
		{portal.left_x, portal.left_y, portal.left_z} = '0;
		{portal.right_x, portal.right_y, portal.right_z} = '0;
		portal.last_portal = 1'b0;
		path.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: single-portal corridor, extremes, repeated end point, overflow
		queue_fixed(z0, z0, 1'b1);
		queue_fixed(hi, lo, 1'b0);
		queue_fixed(lo, hi, 1'b1);
		queue_fixed(lo, lo, 1'b0);
		queue_fixed(hi, hi, 1'b0);
		queue_fixed(lo, lo, 1'b1);
		queue_fixed({16'sd0, 16'sd5, 16'sd0}, {16'sd100, 16'sd0, 16'sd0}, 1'b0);
		queue_fixed({16'sd0, 16'sd5, 16'sd0}, {16'sd100, 16'sd0, 16'sd0}, 1'b1);
		for (int i = 0; i < 34; i++)
			queue_fixed(rand_point(i % 4), rand_point((i + 1) % 4), i == 33);
		wait (pending_portals.size() == 0);

		// Random corridors under three idling patterns, with one long receive stall
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 58 : 0;
			recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 20 : 0;
			if (phase == 1) hold_off = 400;
			for (int c = 0; c < 10; c++)
				queue_corridor(($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
					: $urandom_range(2, 10));
			wait (pending_portals.size() == 0);
		end
		stim_done = 1'b1;
	end

	// End once every point has arrived and the pipe has drained
	initial begin
		wait (stim_done);
		wait (expected_points.size() == 0);
		repeat (200) @(posedge clk);
		if (failures == 0 && expected_points.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

// File: funnel_path_smoother.f
design/fps_pkg.sv
design/fps_if.sv
design/fps_ram.sv
design/fps_datapath.sv
design/fps_ctrl.sv
design/funnel_path_smoother.sv
verif/fps_tb_if.sv
verif/funnel_path_smoother_tb.sv
